// ===== rtl/core/sorted_list_insert_remove_assert.svh =====
// Assertion macros used by the checker file of the sorted list.
`ifndef SORTED_LIST_INSERT_REMOVE_ASSERT_SVH
`define SORTED_LIST_INSERT_REMOVE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SLIR_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SLIR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/slir_pkg.sv =====
package slir_pkg;

    // Capacity of the sorted store and the widths that follow from it.
    localparam int DEPTH = 16;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);

    // Fixed field widths of the request and result.
    localparam int VALUE_W       = 32;
    localparam int STATUS_W      = 2;
    localparam int ENTRY_COUNT_W = 5;

    // Request kinds.
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_REMOVE = 1'b1;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd3;

    typedef logic signed [VALUE_W-1:0] t_value;
    typedef logic [CNT_W-1:0]          t_count;

    typedef struct packed {
        logic   req_type;
        t_value value;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic [ENTRY_COUNT_W-1:0] entry_count;
        t_value                   smallest;
        t_value                   largest;
    } t_res;

    // Broadcast from the top level to every cell of the chain.
    typedef struct packed {
        logic   insert_en;
        logic   remove_en;
        t_value value;
    } t_cell_ctl;

endpackage

// ===== rtl/core/slir_cell.sv =====
module slir_cell import slir_pkg::*; (
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  logic      i_valid,
    input  t_value    i_left_value,
    input  logic      i_left_gt,
    input  t_value    i_right_value,
    output t_value    o_value,
    output logic      o_gt,
    output logic      o_match
);

    t_value r_value;
    t_value n_value;
    logic   ge;

    // Compare the held entry against the broadcast value.
    always_comb begin
        o_gt    = i_valid && (r_value > i_ctl.value);
        o_match = i_valid && (r_value == i_ctl.value);
        ge      = (r_value >= i_ctl.value);
    end

    // An insert shifts the entries above the slot one cell up and drops the value
    // into the first slot that is greater or free; a remove pulls every entry from
    // the first match on one cell down.
    always_comb begin
        n_value = r_value;
        if (i_ctl.insert_en) begin
            if (i_left_gt) begin
                n_value = i_left_value;
            end else if (o_gt || !i_valid) begin
                n_value = i_ctl.value;
            end
        end else if (i_ctl.remove_en && ge) begin
            n_value = i_right_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

// ===== rtl/core/sorted_list_insert_remove.sv =====
// Channel   Direction  Payload  Handshake
// request   in         t_req    i_in_valid / o_in_stall
// result    out        t_res    o_out_valid / i_out_stall
//
// One request is taken per cycle while the input is not stalled; all cells compare and shift in the same edge.
// A result passes from the status register into the output register once that register is free.
// Reset (synchronous, active low) empties the store and clears both handshakes.
// A stalled result holds; requests stall only while a finished status waits
// behind a stalled output register.
module sorted_list_insert_remove import slir_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_req i_in_req,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_res o_out_res
);

    t_count    r_count;
    t_count    n_count;
    logic      r_pend;
    logic      n_pend;
    logic [STATUS_W-1:0] r_status;
    logic [STATUS_W-1:0] n_status;
    logic      r_out_valid;
    logic      n_out_valid;
    t_res      r_out_res;
    t_res      n_out_res;

    t_cell_ctl ctl;
    logic      accept;
    logic      load;
    logic      found;
    logic      full;
    logic [IDX_W-1:0] last_idx;

    t_value cell_value [DEPTH];
    logic   cell_gt    [DEPTH];
    logic   cell_match [DEPTH];
    logic   cell_valid [DEPTH];
    logic [DEPTH-1:0] match_vec;

    // Handshake: the status stage moves on when the output register is free.
    assign load       = r_pend && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_pend && !load;
    assign accept     = i_in_valid && !o_in_stall;

    // Chain of cells, each told whether it lies below the count.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_value left_value;
        logic   left_gt;
        t_value right_value;

        assign cell_valid[g] = (CNT_W'(g) < r_count);
        assign match_vec[g]  = cell_match[g];

        if (g == 0) begin : g_first
            assign left_value = '0;
            assign left_gt    = 1'b0;
        end else begin : g_inner
            assign left_value = cell_value[g-1];
            assign left_gt    = cell_gt[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign right_value = '0;
        end else begin : g_body
            assign right_value = cell_value[g+1];
        end

        slir_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (ctl),
            .i_valid      (cell_valid[g]),
            .i_left_value (left_value),
            .i_left_gt    (left_gt),
            .i_right_value(right_value),
            .o_value      (cell_value[g]),
            .o_gt         (cell_gt[g]),
            .o_match      (cell_match[g])
        );
    end

    // Decode the request into the broadcast control and its status.
    always_comb begin
        found         = |match_vec;
        full          = (r_count == CNT_W'(DEPTH));
        ctl.value     = i_in_req.value;
        ctl.insert_en = accept && (i_in_req.req_type == REQ_INSERT) && !full;
        ctl.remove_en = accept && (i_in_req.req_type == REQ_REMOVE) && found;

        n_count = r_count;
        if (ctl.insert_en) begin
            n_count = r_count + 1'b1;
        end else if (ctl.remove_en) begin
            n_count = r_count - 1'b1;
        end

        n_status = r_status;
        if (accept) begin
            if (i_in_req.req_type == REQ_INSERT) begin
                n_status = full ? ST_FULL : ST_OK;
            end else if (r_count == '0) begin
                n_status = ST_EMPTY;
            end else begin
                n_status = found ? ST_OK : ST_NOT_FOUND;
            end
        end

        n_pend = accept ? 1'b1 : (load ? 1'b0 : r_pend);
    end

    // Result register: the store is settled the cycle after the request.
    always_comb begin
        last_idx    = IDX_W'(r_count - 1'b1);
        n_out_res   = r_out_res;
        n_out_valid = r_out_valid && i_out_stall;
        if (load) begin
            n_out_valid           = 1'b1;
            n_out_res.status      = r_status;
            n_out_res.entry_count = ENTRY_COUNT_W'(r_count);
            if (r_count == '0) begin
                n_out_res.smallest = '0;
                n_out_res.largest  = '0;
            end else begin
                n_out_res.smallest = cell_value[0];
                n_out_res.largest  = cell_value[last_idx];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status  <= n_status;
        r_out_res <= n_out_res;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out_res;

endmodule

// ===== rtl/core/slir_check.sv =====
`include "sorted_list_insert_remove_assert.svh"

module slir_check import slir_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_out_valid,
    input logic i_out_stall,
    input t_res o_out_res
);

    // The count never exceeds the capacity.
    `SLIR_ASSERT_SAME(a_count_range, o_out_valid, o_out_res.entry_count <= ENTRY_COUNT_W'(DEPTH), "entry count beyond capacity")

    // An empty store reports zero bounds.
    `SLIR_ASSERT_SAME(a_empty_zero, o_out_valid && (o_out_res.entry_count == '0), (o_out_res.smallest == '0) && (o_out_res.largest == '0), "empty store with nonzero bounds")

    // A nonempty store is ordered.
    `SLIR_ASSERT_SAME(a_ordered, o_out_valid && (o_out_res.entry_count != '0), o_out_res.smallest <= o_out_res.largest, "smallest above largest")

    // A dropped insert only happens at capacity.
    `SLIR_ASSERT_SAME(a_full_count, o_out_valid && (o_out_res.status == ST_FULL), o_out_res.entry_count == ENTRY_COUNT_W'(DEPTH), "full status below capacity")

    // A stalled result holds.
    `SLIR_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_res), "stalled result changed")

endmodule

bind sorted_list_insert_remove slir_check u_slir_check (.*);
